FILE: design/assert_macros.svh
// Assertion helper macros shared by the RTL files.
// Included by name; compiles to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: design/zba_pkg.sv
// Package for the zone bitmap allocator: sizes, request and status codes,
// and the find-first-zero helper. No dependencies.
`timescale 1ns / 1ps
package zba_pkg;

  // Map geometry
  localparam int WORD_W      = 64;
  localparam int BIT_W       = 6;                        // bit within a word
  localparam int MEM_DEPTH   = 1024;                     // 64-bit map words
  localparam int ADDR_W      = 10;
  localparam int SUM_ADDR_W  = 4;                        // summary rows
  localparam int IDX_W       = ADDR_W + BIT_W;           // 0-based zone index
  localparam int ZONE_W      = 17;
  localparam int BLK_W       = 4;
  localparam logic [BLK_W-1:0] MAX_BLOCKS   = 4'd8;
  localparam logic [BLK_W-1:0] BLOCKS_RESET = 4'd8;
  localparam int BLK_SHIFT   = 13;                       // log2 of 8192 zones a block

  // Request codes
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_FIND  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RMW   = 5'b00100,
    S_FSUM  = 5'b01000,
    S_FDATA = 5'b10000
  } state_e;

  // Index of the lowest clear bit of a word (0 when the word is all ones)
  function automatic logic [BIT_W-1:0] ffz(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage

FILE: design/zone_bitmap_allocator_core.sv
// Zone bitmap allocator top level: bitmap memory, full-word summary memory
// and the request controller. Depends on zba_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage
//   A request (action_i, zone_number_i, set_value_i) is taken at a rising
//   edge with start_i high and busy_o low. One result per request appears on
//   status_o / bit_value_o / free_zone_o, flagged by done_o for exactly one
//   cycle; the receiver cannot stall, so the result must be taken then.
//   cfg_we_i writes cfg_wdata_i into the blocks-in-use register; write it
//   only while the block is idle.
// Sequence
//   Out-of-range, unused action or find with no blocks: the result is
//   registered straight from the idle state. Read or write: one memory
//   read, then the result (and for a write the write-back). Find: a summary
//   scan of one row per cycle over 1 .. 16 rows (two per map block), then one
//   read of the chosen bitmap word, which is skipped when every row is full.
// Request overlap
//   Requests do not overlap: the next one can be taken at the edge that
//   takes the result.
// Reset
//   After reset both memories are swept to zero, one word a cycle, across
//   all 1024 map words with busy_o high; configuration writes are still taken.
//
module zone_bitmap_allocator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 action_i,
  input  logic [zba_pkg::ZONE_W-1:0] zone_number_i,
  input  logic                       set_value_i,
  // result
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic                       bit_value_o,
  output logic [zba_pkg::ZONE_W-1:0] free_zone_o,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [zba_pkg::BLK_W-1:0]  cfg_wdata_i
);

  localparam int W  = zba_pkg::WORD_W;
  localparam int AW = zba_pkg::ADDR_W;
  localparam int SW = zba_pkg::SUM_ADDR_W;
  localparam int BW = zba_pkg::BIT_W;
  localparam int IW = zba_pkg::IDX_W;
  localparam int ZW = zba_pkg::ZONE_W;
  localparam int KW = zba_pkg::BLK_W;

  // Bitmap and summary storage (summary bit set = bitmap word all ones)
  logic [W-1:0] dat_mem [zba_pkg::MEM_DEPTH];
  logic [W-1:0] sum_mem [2**SW];

  zba_pkg::state_e state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [KW-1:0]   blocks_q;
  logic            is_wr_q, is_wr_d;
  logic            set_q, set_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [SW-1:0]   row_q, row_d;
  logic [AW-1:0]   fword_q, fword_d;
  logic            done_q, done_d;
  logic [1:0]      status_q, status_d;
  logic            bitv_q, bitv_d;
  logic [ZW-1:0]   free_q, free_d;

  logic            dat_we, dat_re, sum_we, sum_re;
  logic [AW-1:0]   dat_waddr, dat_raddr;
  logic [SW-1:0]   sum_waddr, sum_raddr;
  logic [W-1:0]    dat_wdata, sum_wdata, dat_rd_q, sum_rd_q, new_word;
  logic [KW-1:0]   blocks_used;
  logic [KW:0]     last_row;
  logic [ZW-1:0]   zone_idx;
  logic            in_range;

  // Effective block count and request decode
  assign blocks_used = (blocks_q > zba_pkg::MAX_BLOCKS) ? zba_pkg::MAX_BLOCKS : blocks_q;
  assign last_row    = {blocks_used, 1'b0} - (KW+1)'(1);
  assign zone_idx    = zone_number_i - ZW'(1);
  assign in_range    = (zone_number_i != '0) &&
                       (zone_idx[ZW-1:zba_pkg::BLK_SHIFT] < blocks_used);

  // Write-back word for a bit write
  always_comb begin
    new_word = dat_rd_q;
    new_word[idx_q[BW-1:0]] = set_q;
  end

  // Controller
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    is_wr_d   = is_wr_q;
    set_d     = set_q;
    idx_d     = idx_q;
    row_d     = row_q;
    fword_d   = fword_q;
    done_d    = 1'b0;
    status_d  = status_q;
    bitv_d    = bitv_q;
    free_d    = free_q;
    dat_we    = 1'b0;
    dat_waddr = '0;
    dat_wdata = '0;
    dat_re    = 1'b0;
    dat_raddr = '0;
    sum_we    = 1'b0;
    sum_waddr = '0;
    sum_wdata = '0;
    sum_re    = 1'b0;
    sum_raddr = '0;
    unique case (state_q)
      zba_pkg::S_CLEAR: begin
        dat_we    = 1'b1;
        dat_waddr = clr_q;
        sum_we    = 1'b1;
        sum_waddr = clr_q[SW-1:0];
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(zba_pkg::MEM_DEPTH - 1)) state_d = zba_pkg::S_IDLE;
      end
      zba_pkg::S_IDLE: begin
        if (start_i) begin
          status_d = zba_pkg::ST_OK;
          bitv_d   = 1'b0;
          free_d   = '0;
          unique case (action_i) inside
            zba_pkg::ACT_READ, zba_pkg::ACT_WRITE: begin
              if (in_range) begin
                is_wr_d   = (action_i == zba_pkg::ACT_WRITE);
                set_d     = set_value_i;
                idx_d     = zone_idx[IW-1:0];
                dat_re    = 1'b1;
                dat_raddr = zone_idx[IW-1:BW];
                sum_re    = 1'b1;
                sum_raddr = zone_idx[IW-1:IW-SW];
                state_d   = zba_pkg::S_RMW;
              end else begin
                status_d = zba_pkg::ST_RANGE;
                done_d   = 1'b1;
              end
            end
            zba_pkg::ACT_FIND: begin
              if (blocks_used == '0) begin
                status_d = zba_pkg::ST_FULL;
                done_d   = 1'b1;
              end else begin
                row_d     = '0;
                sum_re    = 1'b1;
                sum_raddr = '0;
                state_d   = zba_pkg::S_FSUM;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      zba_pkg::S_RMW: begin
        // Read data of the addressed word is back; finish the request
        if (is_wr_q) begin
          dat_we    = 1'b1;
          dat_waddr = idx_q[IW-1:BW];
          dat_wdata = new_word;
          sum_we    = 1'b1;
          sum_waddr = idx_q[IW-1:IW-SW];
          sum_wdata = sum_rd_q;
          sum_wdata[idx_q[IW-SW-1:BW]] = &new_word;
        end else begin
          bitv_d = dat_rd_q[idx_q[BW-1:0]];
        end
        done_d  = 1'b1;
        state_d = zba_pkg::S_IDLE;
      end
      zba_pkg::S_FSUM: begin
        // One summary row per cycle until a word with a clear bit shows up or the last row in use is full
        if (sum_rd_q != '1) begin
          fword_d   = {row_q, zba_pkg::ffz(sum_rd_q)};
          dat_re    = 1'b1;
          dat_raddr = fword_d;
          state_d   = zba_pkg::S_FDATA;
        end else if ({1'b0, row_q} == last_row) begin
          status_d = zba_pkg::ST_FULL;
          done_d   = 1'b1;
          state_d  = zba_pkg::S_IDLE;
        end else begin
          row_d     = row_q + SW'(1);
          sum_re    = 1'b1;
          sum_raddr = row_d;
        end
      end
      zba_pkg::S_FDATA: begin
        free_d  = {1'b0, fword_q, zba_pkg::ffz(dat_rd_q)} + ZW'(1);
        done_d  = 1'b1;
        state_d = zba_pkg::S_IDLE;
      end
      default: state_d = zba_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= zba_pkg::S_CLEAR;
      clr_q    <= '0;
      done_q   <= 1'b0;
      blocks_q <= zba_pkg::BLOCKS_RESET;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      if (cfg_we_i) blocks_q <= cfg_wdata_i;
    end
  end

  // Request context and result payload
  always_ff @(posedge clk_i) begin
    is_wr_q  <= is_wr_d;
    set_q    <= set_d;
    idx_q    <= idx_d;
    row_q    <= row_d;
    fword_q  <= fword_d;
    status_q <= status_d;
    bitv_q   <= bitv_d;
    free_q   <= free_d;
  end

  // Bitmap memory, registered read
  always_ff @(posedge clk_i) begin
    if (dat_we) dat_mem[dat_waddr] <= dat_wdata;
    if (dat_re) dat_rd_q <= dat_mem[dat_raddr];
  end

  // Summary memory, registered read
  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    if (sum_re) sum_rd_q <= sum_mem[sum_raddr];
  end

  assign busy_o      = (state_q != zba_pkg::S_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign bit_value_o = bitv_q;
  assign free_zone_o = free_q;

  // Summary says the chosen word has a clear bit
  `ASSERT_NEVER(a_fdata_word_full, clk_i, rst_ni,
                (state_q == zba_pkg::S_FDATA) && (dat_rd_q == '1),
                "summary pointed at a full bitmap word")
  // Scan never runs past the rows in use
  `ASSERT_CLK(a_row_in_use, clk_i, rst_ni,
              (state_q == zba_pkg::S_FSUM) |-> ({1'b0, row_q} <= last_row),
              "summary scan beyond blocks in use")
  // A full map reports no zone and no bit
  `ASSERT_CLK(a_full_clean, clk_i, rst_ni,
              (done_o && status_o == zba_pkg::ST_FULL) |-> (free_zone_o == '0 && !bit_value_o),
              "full status with nonzero payload")

endmodule
